// ===== rtl/fpir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpir_pkg
// shared types and constants of the fixed point image rotator
// ----------------------------------------------------------------------------
package fpir_pkg;

    // field widths of the channels
    localparam int COORD_W   = 9;
    localparam int PIXEL_W   = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    // configuration register widths
    localparam int TRIG_W = 18;
    localparam int DIM_W  = 9;
    localparam int SCEN_W = 24;
    localparam int DCEN_W = 25;

    // configuration reset values
    localparam logic signed [TRIG_W-1:0] COS_RST  = 18'sd65536;
    localparam logic signed [TRIG_W-1:0] SIN_RST  = 18'sd0;
    localparam logic [DIM_W-1:0]         DIM_RST  = 9'd256;
    localparam logic [SCEN_W-1:0]        SCEN_RST = 24'd8388608;
    localparam logic [DCEN_W-1:0]        DCEN_RST = 25'd8388608;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_FETCH = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_COS = 4'd0,
        CFG_ROT_SIN = 4'd1,
        CFG_SRC_W   = 4'd2,
        CFG_SRC_H   = 4'd3,
        CFG_SRC_CX  = 4'd4,
        CFG_SRC_CY  = 4'd5,
        CFG_DST_CX  = 4'd6,
        CFG_DST_CY  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [PIXEL_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               inside_res;
    } t_out_item;

endpackage

// ===== rtl/fixed_point_image_rotator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_image_rotator
// nearest neighbour image rotation by inverse mapping in fixed point
// ----------------------------------------------------------------------------
// The block takes one transaction per clock unless the input stalls, loads and fetches
// mixed freely, and returns one result transaction per fetch via stages 1 to 4 and the
// output register (none for a load). A load writes one pixel of the source frame into an
// on-chip single-port-style store (one write and one read port, one access
// per item); a fetch maps its destination coordinate back into the source
// frame through a five stage pipeline: centre offset, four 16.16 products,
// rotate-and-recentre sums with rounding, bounds check plus store access,
// and the output register. Both loads and fetches touch the store in the same
// stage, so every fetch sees exactly the loads accepted before it and no
// forwarding is needed. Stages that hold no transaction are filled while the
// output waits, so the input only stalls once every stage is occupied. The
// store is not cleared: a fetch landing on a pixel that was never loaded
// returns whatever the memory holds. Configuration may only be written while
// no fetch is in flight; the configuration port is always ready.
// ----------------------------------------------------------------------------
module fixed_point_image_rotator #(
    parameter int SRC_DIM_BITS = 8,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fpir_pkg::t_in_item                  i_in_data,
    // result output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fpir_pkg::t_out_item                 o_out_data,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpir_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpir_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import fpir_pkg::*;

    // datapath widths, all derived from the parameters
    localparam int RXW  = ((COORD_W + FRAC_BITS > DCEN_W) ? COORD_W + FRAC_BITS : DCEN_W) + 1;
    localparam int PW   = RXW + TRIG_W;
    localparam int SHW  = PW - FRAC_BITS;
    localparam int SW   = ((SHW > SCEN_W) ? SHW : SCEN_W) + 3;
    localparam int IXW  = SW - FRAC_BITS;
    localparam int CW   = (IXW > 14) ? IXW : 14;
    localparam int XW   = ((COORD_W > SRC_DIM_BITS) ? COORD_W : SRC_DIM_BITS) + 1;
    localparam int MAW  = 2 * SRC_DIM_BITS;
    localparam int DEPTH = 1 << MAW;

    localparam logic [SW-1:0] HALF_Q   = {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [CW-1:0] SIDE_C   = CW'(1) << SRC_DIM_BITS;
    localparam logic [XW-1:0] SIDE_X   = XW'(1) << SRC_DIM_BITS;

    // configuration registers
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic [DIM_W-1:0]         r_src_w;
    logic [DIM_W-1:0]         r_src_h;
    logic [SCEN_W-1:0]        r_scx;
    logic [SCEN_W-1:0]        r_scy;
    logic [DCEN_W-1:0]        r_dcx;
    logic [DCEN_W-1:0]        r_dcy;

    // stage 1: offsets from the destination centre
    logic                     r_v1;
    logic                     r_act1;
    logic [COORD_W-1:0]       r_x1, r_y1;
    logic [PIXEL_W-1:0]       r_pix1;
    logic signed [RXW-1:0]    r_rx1, r_ry1;
    logic [RXW-1:0]           n_rx, n_ry;

    // stage 2: rotation products
    logic                     r_v2;
    logic                     r_act2;
    logic [COORD_W-1:0]       r_x2, r_y2;
    logic [PIXEL_W-1:0]       r_pix2;
    logic signed [PW-1:0]     r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [PW-1:0]     n_pxc, n_pys, n_pxs, n_pyc;

    // stage 3: source coordinate plus one half
    logic                     r_v3;
    logic                     r_act3;
    logic [COORD_W-1:0]       r_x3, r_y3;
    logic [PIXEL_W-1:0]       r_pix3;
    logic [SW-1:0]            r_sx3, r_sy3;
    logic [SW-1:0]            n_sx, n_sy;

    // stage 4: store read data
    logic                     r_v4;
    logic                     r_in4;
    logic [PIXEL_W-1:0]       r_rd4;

    // output register
    logic                     r_ov;
    t_out_item                r_out;

    // frame store
    logic [PIXEL_W-1:0]       mem [DEPTH];

    logic                     rdy_o, rdy4, rdy3, rdy2, rdy1;
    logic                     in_acc;
    logic [CW-1:0]            ix_c, iy_c, w_c, h_c;
    logic                     n_inside;
    logic [XW-1:0]            lx, ly;
    logic                     ld_in_store;
    logic                     mem_we, mem_re;
    logic [MAW-1:0]           mem_addr;

    // ------------------------------------------------------------------------
    // configuration port, always ready, unknown indexes dropped
    // ------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos   <= COS_RST;
            r_sin   <= SIN_RST;
            r_src_w <= DIM_RST;
            r_src_h <= DIM_RST;
            r_scx   <= SCEN_RST;
            r_scy   <= SCEN_RST;
            r_dcx   <= DCEN_RST;
            r_dcy   <= DCEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROT_COS: r_cos   <= $signed(i_cfg_data[TRIG_W-1:0]);
                CFG_ROT_SIN: r_sin   <= $signed(i_cfg_data[TRIG_W-1:0]);
                CFG_SRC_W:   r_src_w <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_H:   r_src_h <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_CX:  r_scx   <= i_cfg_data[SCEN_W-1:0];
                CFG_SRC_CY:  r_scy   <= i_cfg_data[SCEN_W-1:0];
                CFG_DST_CX:  r_dcx   <= i_cfg_data[DCEN_W-1:0];
                CFG_DST_CY:  r_dcy   <= i_cfg_data[DCEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pipeline flow: a stage moves on when the next one is empty or moving
    // ------------------------------------------------------------------------
    assign rdy_o = !r_ov || !i_out_stall;
    assign rdy4  = !r_v4 || rdy_o;
    assign rdy3  = !r_v3 || rdy4;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;

    assign o_in_stall = !rdy1;
    assign in_acc     = i_in_valid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            // loads end in stage 3, only fetches go on
            if (rdy4) begin
                r_v4 <= r_v3 && (r_act3 == ACT_FETCH);
            end
            if (rdy_o) begin
                r_ov <= r_v4;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: x*one - dcx, y*one - dcy
    // ------------------------------------------------------------------------
    assign n_rx = {{(RXW-COORD_W-FRAC_BITS){1'b0}}, i_in_data.coord_x, {FRAC_BITS{1'b0}}}
                - {{(RXW-DCEN_W){1'b0}}, r_dcx};
    assign n_ry = {{(RXW-COORD_W-FRAC_BITS){1'b0}}, i_in_data.coord_y, {FRAC_BITS{1'b0}}}
                - {{(RXW-DCEN_W){1'b0}}, r_dcy};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act1 <= i_in_data.action;
            r_x1   <= i_in_data.coord_x;
            r_y1   <= i_in_data.coord_y;
            r_pix1 <= i_in_data.pixel_in;
            r_rx1  <= $signed(n_rx);
            r_ry1  <= $signed(n_ry);
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: the four rotation products
    // ------------------------------------------------------------------------
    assign n_pxc = r_rx1 * r_cos;
    assign n_pys = r_ry1 * r_sin;
    assign n_pxs = r_rx1 * r_sin;
    assign n_pyc = r_ry1 * r_cos;

    always_ff @(posedge i_clk) begin
        if (r_v1 && rdy2) begin
            r_act2 <= r_act1;
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_pix2 <= r_pix1;
            r_pxc  <= n_pxc;
            r_pys  <= n_pys;
            r_pxs  <= n_pxs;
            r_pyc  <= n_pyc;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: floor-shifted products, recentre, add one half for rounding
    // ------------------------------------------------------------------------
    assign n_sx = SW'($signed(r_pxc[PW-1:FRAC_BITS])) - SW'($signed(r_pys[PW-1:FRAC_BITS]))
                + {{(SW-SCEN_W){1'b0}}, r_scx} + HALF_Q;
    assign n_sy = SW'($signed(r_pxs[PW-1:FRAC_BITS])) + SW'($signed(r_pyc[PW-1:FRAC_BITS]))
                + {{(SW-SCEN_W){1'b0}}, r_scy} + HALF_Q;

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            r_act3 <= r_act2;
            r_x3   <= r_x2;
            r_y3   <= r_y2;
            r_pix3 <= r_pix2;
            r_sx3  <= n_sx;
            r_sy3  <= n_sy;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: bounds check and the single store access of the item
    // ------------------------------------------------------------------------
    // integer source coordinate, floor of the rounded sum
    assign ix_c = CW'($signed(r_sx3[SW-1:FRAC_BITS]));
    assign iy_c = CW'($signed(r_sy3[SW-1:FRAC_BITS]));

    // frame larger than the store is clipped to the store
    assign w_c = (CW'(r_src_w) > SIDE_C) ? SIDE_C : CW'(r_src_w);
    assign h_c = (CW'(r_src_h) > SIDE_C) ? SIDE_C : CW'(r_src_h);

    assign n_inside = !ix_c[CW-1] && !iy_c[CW-1] && (ix_c < w_c) && (iy_c < h_c);

    // loads beyond the store are dropped
    assign lx          = XW'(r_x3);
    assign ly          = XW'(r_y3);
    assign ld_in_store = (lx < SIDE_X) && (ly < SIDE_X);

    assign mem_we   = r_v3 && rdy4 && (r_act3 == ACT_LOAD) && ld_in_store;
    assign mem_re   = r_v3 && rdy4 && (r_act3 == ACT_FETCH) && n_inside;
    assign mem_addr = (r_act3 == ACT_LOAD)
                    ? {ly[SRC_DIM_BITS-1:0], lx[SRC_DIM_BITS-1:0]}
                    : {iy_c[SRC_DIM_BITS-1:0], ix_c[SRC_DIM_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= r_pix3;
        end
        if (mem_re) begin
            r_rd4 <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy4) begin
            r_in4 <= n_inside;
        end
    end

    // ------------------------------------------------------------------------
    // output register, black outside the frame
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_v4 && rdy_o) begin
            r_out.pixel_out  <= r_in4 ? r_rd4 : '0;
            r_out.inside_res <= r_in4;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a waiting fetch in stage 4 keeps its read data while the output is blocked
    a_rd_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_ov && i_out_stall) |=> (r_v4 && $stable(r_rd4) && $stable(r_in4)))
        else $error("stage 4 read data lost while output stalled");

    // a load leaving stage 3 never turns into a result
    a_load_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && rdy4 && (r_act3 == ACT_LOAD)) |=> !r_v4)
        else $error("load produced a result");

    // input stalls only with every stage occupied
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_ov))
        else $error("input stalled with a free stage");

    // a result outside the frame is black
    a_outside_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.inside_res) |-> (o_out_data.pixel_out == '0))
        else $error("outside result not black");
`endif

endmodule
